// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the servo reply parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, masked while arst_n is low.
`define SRFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never hold at a clock edge.
`define SRFP_NEVER(lbl, cond, msg) \
	`SRFP_ASSERT(lbl, !(cond), msg)

`endif

// File: hw/rtl/srfp_pkg.sv
// Shared constants and types of the servo reply frame parser.
`timescale 1ns / 1ps

package srfp_pkg;

	localparam logic [7:0] RESET_HEADER = 8'd85;
	localparam logic [7:0] MIN_LEN = 8'd3;
	localparam int LEN_MARGIN = 3;

	localparam int POS_ID = 2;
	localparam int POS_LEN = 3;
	localparam int FIRST_PAYLOAD = 4;

	// Two frame banks, so the queue holds at most two frames.
	localparam int QUEUE_DEPTH = 2;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_RUN = 2'b10
	} srfp_bk_state_t;

endpackage

// File: hw/rtl/srfp_queue.sv
// Two-entry descriptor queue between the frame front end and the result back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srfp_queue import srfp_pkg::*; #(
	parameter int W = 8
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [W-1:0] push_data,
	input logic pop,
	output logic [W-1:0] head,
	output logic full,
	output logic empty
);

	logic [W-1:0] ent_q [QUEUE_DEPTH];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign full = count_q == 2'(QUEUE_DEPTH);
	assign empty = count_q == 2'd0;
	assign head = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_data;
	end

	`SRFP_NEVER(a_push_full, push && full, "descriptor pushed into full queue")
	`SRFP_NEVER(a_pop_empty, pop && empty, "descriptor popped from empty queue")

endmodule

// File: hw/rtl/srfp_front.sv
// Front end: header hunt, frame field capture, checksum check, payload writes.
`timescale 1ns / 1ps

module srfp_front import srfp_pkg::*; #(
	parameter int BUFFER_BYTES = 32,
	localparam int PW = $clog2(BUFFER_BYTES),
	localparam int AW = PW + 1
) (
	input logic clk,
	input logic arst_n,
	input logic [7:0] header_value,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] rx_byte,
	input logic q_full,
	output logic push,
	output logic [PW+1:0] push_desc,
	output logic [AW+8:0] wr
);

	typedef struct packed {
		logic err;
		logic bank;
		logic [PW-1:0] last_pos;
	} srfp_desc_t;

	typedef struct packed {
		logic en;
		logic [AW-1:0] addr;
		logic [7:0] data;
	} srfp_wr_t;

	localparam logic [7:0] LEN_MAX = 8'(BUFFER_BYTES - LEN_MARGIN);

	logic in_frame_q;
	logic hdr_seen_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] len_q;
	logic [7:0] sum_q;
	logic bank_q;

	logic acc;
	logic is_id;
	logic is_len;
	logic in_body;
	logic len_ok;
	srfp_desc_t desc;
	srfp_wr_t wr_s;

	assign in_stall = q_full;
	assign acc = in_valid && !q_full;
	assign is_id = pos_q == PW'(POS_ID);
	assign is_len = pos_q == PW'(POS_LEN);
	assign in_body = {1'b0, pos_q} < ({1'b0, len_q} + (PW+1)'(2));
	assign len_ok = rx_byte >= MIN_LEN && rx_byte <= LEN_MAX;

	assign push = acc && in_frame_q && !is_id && !is_len && !in_body;
	assign desc.err = ~sum_q != rx_byte;
	assign desc.bank = bank_q;
	assign desc.last_pos = len_q + PW'(1);
	assign push_desc = desc;

	assign wr_s.en = acc && in_frame_q && !is_id && !is_len && in_body;
	assign wr_s.addr = {bank_q, pos_q};
	assign wr_s.data = rx_byte;
	assign wr = wr_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			hdr_seen_q <= 1'b0;
			pos_q <= '0;
			len_q <= '0;
			sum_q <= 8'd0;
			bank_q <= 1'b0;
		end else if (acc) begin
			if (!in_frame_q) begin
				if (rx_byte == header_value) begin
					if (hdr_seen_q) begin
						hdr_seen_q <= 1'b0;
						in_frame_q <= 1'b1;
						pos_q <= PW'(POS_ID);
						len_q <= '0;
						sum_q <= 8'd0;
					end else begin
						hdr_seen_q <= 1'b1;
					end
				end else begin
					hdr_seen_q <= 1'b0;
				end
			end else if (is_id) begin
				sum_q <= sum_q + rx_byte;
				pos_q <= PW'(POS_LEN);
			end else if (is_len) begin
				if (len_ok) begin
					len_q <= rx_byte[PW-1:0];
					sum_q <= sum_q + rx_byte;
					pos_q <= PW'(FIRST_PAYLOAD);
				end else begin
					in_frame_q <= 1'b0;
					hdr_seen_q <= 1'b0;
				end
			end else if (in_body) begin
				sum_q <= sum_q + rx_byte;
				pos_q <= pos_q + PW'(1);
			end else begin
				in_frame_q <= 1'b0;
				hdr_seen_q <= 1'b0;
				bank_q <= ~bank_q;
			end
		end
	end

endmodule

// File: hw/rtl/srfp_back.sv
// Back end: payload memory and result sequencer with output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srfp_back import srfp_pkg::*; #(
	parameter int BUFFER_BYTES = 32,
	localparam int PW = $clog2(BUFFER_BYTES),
	localparam int AW = PW + 1
) (
	input logic clk,
	input logic arst_n,
	input logic [AW+8:0] wr,
	input logic q_empty,
	input logic [PW+1:0] head,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output logic status,
	output logic [7:0] data_byte,
	output logic last
);

	typedef struct packed {
		logic err;
		logic bank;
		logic [PW-1:0] last_pos;
	} srfp_desc_t;

	typedef struct packed {
		logic en;
		logic [AW-1:0] addr;
		logic [7:0] data;
	} srfp_wr_t;

	localparam int MEM_WORDS = 2 ** AW;

	logic [7:0] mem [MEM_WORDS];

	srfp_bk_state_t state_q;
	logic valid_q;
	logic status_q;
	logic last_q;
	logic [PW-1:0] rd_pos_q;
	logic [7:0] rd_q;

	srfp_wr_t wr_s;
	srfp_desc_t hd;
	logic out_free;
	logic rd_en;
	logic run_last;
	logic [AW-1:0] rd_addr;

	assign wr_s = wr;
	assign hd = head;
	assign out_free = !valid_q || !out_stall;
	assign rd_en = state_q == BK_RUN && out_free;
	assign rd_addr = {hd.bank, rd_pos_q};
	assign run_last = rd_pos_q == hd.last_pos;
	assign pop = out_free && ((state_q == BK_IDLE && !q_empty && hd.err) ||
		(rd_en && run_last));

	assign out_valid = valid_q;
	assign status = status_q;
	assign last = last_q;
	assign data_byte = (status_q == STATUS_ERR) ? 8'd0 : rd_q;

	always_ff @(posedge clk) begin
		if (wr_s.en)
			mem[wr_s.addr] <= wr_s.data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			valid_q <= 1'b0;
			status_q <= STATUS_OK;
			last_q <= 1'b0;
			rd_pos_q <= '0;
		end else begin
			case (state_q)
				BK_IDLE: begin
					if (out_free) begin
						valid_q <= !q_empty && hd.err;
						if (!q_empty) begin
							if (hd.err) begin
								status_q <= STATUS_ERR;
								last_q <= 1'b1;
							end else begin
								rd_pos_q <= PW'(FIRST_PAYLOAD);
								state_q <= BK_RUN;
							end
						end
					end
				end
				BK_RUN: begin
					if (out_free) begin
						valid_q <= 1'b1;
						status_q <= STATUS_OK;
						last_q <= run_last;
						rd_pos_q <= rd_pos_q + PW'(1);
						if (run_last)
							state_q <= BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
					if (out_free)
						valid_q <= 1'b0;
				end
			endcase
		end
	end

	`SRFP_ASSERT(a_run_has_frame, state_q != BK_RUN || !q_empty, "run without queued frame")
	`SRFP_ASSERT(a_err_is_last, !(valid_q && status_q == STATUS_ERR) || last_q, "error beat not last")

endmodule

// File: hw/rtl/servo_reply_frame_parser_core.sv
// Top level of the servo reply frame parser: config register, front end, queue, back end.
`timescale 1ns / 1ps

// Takes one received byte per cycle while in_stall is low. Two consecutive header_value
// bytes open a frame (id, length L, command, L-3 parameters, checksum); L outside
// 3..BUFFER_BYTES-3 drops the frame silently. A frame whose checksum matches the
// inverted sum gives L-2 beats (command then parameters, last on the final one), a
// mismatch gives one error beat. Payload lands in a two-bank memory. With the back end
// idle, a good frame's beats leave after the queue entry, run state and output register,
// then one per cycle, paced by the single memory read port and by out_stall; an error
// beat leaves after the queue entry and output register. The sequencer idles before each
// good frame's run. Input stalls only while two finished frames both wait to be drained.
// header_value is written through the cfg port (always ready), reset value 85.

module servo_reply_frame_parser_core import srfp_pkg::*; #(
	parameter int BUFFER_BYTES = 32
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] header_value,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_stall,
	output logic status,
	output logic [7:0] data_byte,
	output logic last
);

	localparam int PW = $clog2(BUFFER_BYTES);
	localparam int AW = PW + 1;
	localparam int DW = PW + 2;

	logic [7:0] header_q;
	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	logic [DW-1:0] push_desc;
	logic [DW-1:0] head;
	logic [AW+8:0] wr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			header_q <= RESET_HEADER;
		else if (cfg_valid)
			header_q <= header_value;
	end

	srfp_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.header_value(header_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.q_full(q_full),
		.push(push),
		.push_desc(push_desc),
		.wr(wr)
	);

	srfp_queue #(.W(DW)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_desc),
		.pop(pop),
		.head(head),
		.full(q_full),
		.empty(q_empty)
	);

	srfp_back #(.BUFFER_BYTES(BUFFER_BYTES)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr(wr),
		.q_empty(q_empty),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.data_byte(data_byte),
		.last(last)
	);

endmodule

// File: tb/srfp_reply_checker.sv
// Scoreboard for the servo reply frame parser: tracks accepted bytes, predicts reply beats, compares.
`timescale 1ns / 1ps

module srfp_reply_checker import srfp_pkg::*; #(
	parameter int BUFFER_BYTES = 32
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [7:0] header_value,
	input logic in_valid,
	input logic in_stall,
	input logic [7:0] rx_byte,
	input logic out_valid,
	input logic out_stall,
	input logic status,
	input logic [7:0] data_byte,
	input logic last,
	output int mismatch_count,
	output int beats_pending
);

	localparam int PW = $clog2(BUFFER_BYTES);

	typedef struct packed {
		logic status;
		logic [7:0] data;
		logic last;
	} reply_beat_t;

	reply_beat_t expected_replies[$];
	reply_beat_t want;

	logic [7:0] hdr_match;
	bit framing;
	bit one_header;
	int frame_pos;
	int frame_len;
	logic [7:0] body_sum;
	logic [7:0] body_store [BUFFER_BYTES];

	task automatic absorb_byte(input logic [7:0] b);
		int stop;
		int i;
		logic [7:0] inv_sum;
		reply_beat_t beat;
		if (!framing) begin
			if (b == hdr_match) begin
				if (one_header) begin
					one_header = 1'b0;
					framing = 1'b1;
					frame_pos = POS_ID;
					frame_len = 0;
					body_sum = 8'd0;
				end else begin
					one_header = 1'b1;
				end
			end else begin
				one_header = 1'b0;
			end
			return;
		end
		if (frame_pos == POS_ID) begin
			body_sum = body_sum + b;
			frame_pos = POS_LEN;
			return;
		end
		if (frame_pos == POS_LEN) begin
			if (b < MIN_LEN || int'(b) > BUFFER_BYTES - LEN_MARGIN) begin
				framing = 1'b0;
				one_header = 1'b0;
				return;
			end
			frame_len = int'(b);
			body_sum = body_sum + b;
			frame_pos = FIRST_PAYLOAD;
			return;
		end
		// checksum sits at index L+2
		stop = frame_len + 2;
		if (frame_pos < stop) begin
			if (frame_pos < BUFFER_BYTES)
				body_store[PW'(frame_pos)] = b;
			body_sum = body_sum + b;
			frame_pos++;
			return;
		end
		framing = 1'b0;
		one_header = 1'b0;
		inv_sum = ~body_sum;
		if (inv_sum == b) begin
			for (i = FIRST_PAYLOAD; i < stop && i < BUFFER_BYTES; i++) begin
				beat.status = STATUS_OK;
				beat.data = body_store[PW'(i)];
				beat.last = (i + 1 == stop);
				expected_replies.push_back(beat);
			end
		end else begin
			beat.status = STATUS_ERR;
			beat.data = 8'd0;
			beat.last = 1'b1;
			expected_replies.push_back(beat);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_match = RESET_HEADER;
			framing = 1'b0;
			one_header = 1'b0;
			frame_pos = 0;
			frame_len = 0;
			body_sum = 8'd0;
			expected_replies.delete();
			mismatch_count = 0;
			beats_pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				hdr_match = header_value;
			if (in_valid && !in_stall)
				absorb_byte(rx_byte);
			if (out_valid && !out_stall) begin
				if (expected_replies.size() == 0) begin
					$error("unexpected beat: status %0d data_byte %02h last %0d",
						status, data_byte, last);
					mismatch_count++;
				end else begin
					want = expected_replies.pop_front();
					if (status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d", want.status, status);
						mismatch_count++;
					end
					if (data_byte !== want.data) begin
						$error("data_byte mismatch: expected %02h, actual %02h",
							want.data, data_byte);
						mismatch_count++;
					end
					if (last !== want.last) begin
						$error("last mismatch: expected %0d, actual %0d", want.last, last);
						mismatch_count++;
					end
				end
			end
			beats_pending = expected_replies.size();
		end
	end

endmodule

// File: tb/servo_reply_frame_parser_core_tb.sv
// Testbench top for the servo reply frame parser: clock, reset, byte and header stimulus, verdict.
`timescale 1ns / 1ps

module servo_reply_frame_parser_core_tb;
	import srfp_pkg::*;

	localparam int BUFFER_BYTES = 32;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES = 600;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [7:0] header_value;
	logic in_valid;
	logic in_stall;
	logic [7:0] rx_byte;
	logic out_valid;
	logic out_stall;
	logic status;
	logic [7:0] data_byte;
	logic last;

	logic gap_stall;
	logic hold_stall;
	bit hold_go;
	logic [7:0] cur_header;
	int bytes_sent;
	int tx_calm;
	int rx_calm;
	int mismatch_count;
	int beats_pending;

	assign out_stall = gap_stall | hold_stall;

	servo_reply_frame_parser_core #(.BUFFER_BYTES(BUFFER_BYTES)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.header_value(header_value),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.data_byte(data_byte),
		.last(last)
	);

	srfp_reply_checker #(.BUFFER_BYTES(BUFFER_BYTES)) chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.header_value(header_value),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.data_byte(data_byte),
		.last(last),
		.mismatch_count(mismatch_count),
		.beats_pending(beats_pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	task automatic draw_gap(inout int calm, output int gap);
		if (calm > 0) begin
			calm--;
			gap = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(10, 30);
			gap = 0;
		end else begin
			gap = $urandom_range(0, 9);
		end
	endtask

	// entered and left at a falling edge
	task automatic send_rx(input logic [7:0] b);
		int gap;
		draw_gap(tx_calm, gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (beats_pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_header(input logic [7:0] v);
		cfg_valid <= 1'b1;
		header_value <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_header = v;
	endtask

	task automatic send_frame(input logic [7:0] id, input logic [7:0] len, input bit corrupt);
		logic [7:0] acc;
		logic [7:0] b;
		int k;
		send_rx(cur_header);
		send_rx(cur_header);
		send_rx(id);
		send_rx(len);
		if (len < MIN_LEN || int'(len) > BUFFER_BYTES - LEN_MARGIN)
			return;
		acc = id + len;
		for (k = 0; k < int'(len) - 2; k++) begin
			b = 8'($urandom_range(0, 255));
			acc = acc + b;
			send_rx(b);
		end
		acc = ~acc;
		if (corrupt)
			acc = acc ^ 8'($urandom_range(1, 255));
		send_rx(acc);
	endtask

	task automatic random_phase(input int quota);
		int start;
		int pick;
		logic [7:0] len;
		start = bytes_sent;
		while (bytes_sent - start < quota) begin
			pick = $urandom_range(0, 9);
			if (pick <= 6) begin
				if ($urandom_range(0, 7) == 0)
					len = 8'($urandom_range(9, BUFFER_BYTES - LEN_MARGIN));
				else
					len = 8'($urandom_range(MIN_LEN, 8));
				send_frame(8'($urandom_range(0, 255)), len, 1'b0);
			end else if (pick == 7) begin
				send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(MIN_LEN, 8)), 1'b1);
			end else if (pick == 8) begin
				repeat ($urandom_range(1, 4)) send_rx(8'($urandom_range(0, 255)));
			end else if ($urandom_range(0, 1) == 0) begin
				if ($urandom_range(0, 1) == 0)
					len = 8'($urandom_range(0, MIN_LEN - 1));
				else
					len = 8'($urandom_range(BUFFER_BYTES - LEN_MARGIN + 1, 255));
				send_frame(8'($urandom_range(0, 255)), len, 1'b0);
			end else begin
				// cut short: following bytes land inside this frame
				send_rx(cur_header);
				send_rx(cur_header);
				send_rx(8'($urandom_range(0, 255)));
				send_rx(8'($urandom_range(MIN_LEN, 8)));
				send_rx(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		gap_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			int g;
			draw_gap(rx_calm, g);
			if (g > 0) begin
				gap_stall <= 1'b1;
				repeat (g) @(negedge clk);
			end
			gap_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			@(negedge clk);
		end
	end

	initial begin
		hold_stall = 1'b0;
		wait (hold_go);
		@(negedge clk);
		hold_stall <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_stall <= 1'b0;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		header_value = 8'd0;
		in_valid = 1'b0;
		rx_byte = 8'd0;
		hold_go = 1'b0;
		bytes_sent = 0;
		tx_calm = 0;
		rx_calm = 0;
		cur_header = RESET_HEADER;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// receiver holds off while the directed frames pile up
		hold_go = 1'b1;

		// noise, lone header byte
		send_rx(8'h00);
		send_rx(8'hFF);
		send_rx(cur_header);
		send_rx(8'h12);
		send_frame(8'h01, MIN_LEN, 1'b0);
		send_frame(8'hFE, 8'(BUFFER_BYTES - LEN_MARGIN), 1'b0);
		send_frame(8'h02, MIN_LEN - 8'd1, 1'b0);
		send_frame(8'h03, 8'(BUFFER_BYTES - LEN_MARGIN + 1), 1'b0);
		send_frame(8'h04, 8'd0, 1'b0);
		send_frame(8'h05, 8'd255, 1'b0);
		send_frame(8'h06, 8'd5, 1'b1);
		// header byte repeated three times: third one is the id
		send_frame(cur_header, MIN_LEN, 1'b0);

		// header changes while a frame is half received
		send_rx(cur_header);
		send_rx(cur_header);
		send_rx(8'h21);
		send_rx(8'd4);
		send_rx(8'h5A);
		settle();
		write_header(8'hFF);
		send_rx(8'hA5);
		send_rx(8'hDB);

		random_phase(5);
		settle();
		write_header(8'h00);
		random_phase(5);
		settle();
		write_header(8'($urandom_range(0, 255)));
		random_phase(5);
		settle();
		write_header(RESET_HEADER);
		random_phase(5);

		settle();
		repeat (50) @(negedge clk);
		if (mismatch_count == 0 && beats_pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
